// ===== rtl/nsip_pkg.sv =====
// Package for the nearest segment image point block.
// Holds the queue item types, register indexes and fixed-point constants.
// No dependencies.
package nsip_pkg;

  // Direction fraction bits (Q1.14) and the default table depth.
  localparam int unsigned DirFrac = 14;
  localparam int unsigned MaxSegmentsDef = 256;

  // Configuration register indexes.
  localparam logic [1:0] RegCenterX = 2'd0;
  localparam logic [1:0] RegCenterY = 2'd1;
  localparam logic [1:0] RegRadius  = 2'd2;
  localparam logic [1:0] RegSegCnt  = 2'd3;

  // Item actions.
  localparam logic ActLoad  = 1'b0;
  localparam logic ActQuery = 1'b1;

  // One input item as it travels from the front to the engine.
  typedef struct packed {
    logic               action;
    logic [7:0]         entry_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic signed [31:0] image_x;
    logic signed [31:0] image_y;
    logic [7:0]         nearest_index;
    logic               inside_circle;
  } res_t;

endpackage

// ===== rtl/nsip_fifo.sv =====
// Small register queue used between the block's parts.
// Depends on nothing.
module nsip_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);
  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Storage, no reset needed.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(Depth - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(Depth - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end
endmodule

// ===== rtl/nsip_front.sv =====
// Front part: accepts input items, drops loads aimed outside the table.
// Depends on nsip_pkg.
module nsip_front #(
  parameter int unsigned MaxSegments = nsip_pkg::MaxSegmentsDef
) (
  input  logic               push_i,
  output logic               full_o,
  input  logic               action_i,
  input  logic [7:0]         entry_index_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic               cmd_full_i,
  output logic               cmd_push_o,
  output nsip_pkg::cmd_t     cmd_o
);
  logic in_range;

  // A load beyond the table is taken but has no effect.
  assign in_range = ({24'd0, entry_index_i} < 32'(MaxSegments));
  assign full_o = cmd_full_i;
  assign cmd_push_o = push_i && !cmd_full_i &&
                      ((action_i == nsip_pkg::ActQuery) || in_range);

  always_comb begin
    cmd_o.action      = action_i;
    cmd_o.entry_index = entry_index_i;
    cmd_o.point_x     = point_x_i;
    cmd_o.point_y     = point_y_i;
    cmd_o.dir_x       = dir_x_i;
    cmd_o.dir_y       = dir_y_i;
  end
endmodule

// ===== rtl/nsip_engine.sv =====
// Back part: segment table, pipelined projection scan and image finish.
// Depends on nsip_pkg.
module nsip_engine #(
  parameter int unsigned MaxSegments = nsip_pkg::MaxSegmentsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [31:0]    cfg_data_i,
  input  logic           cmd_empty_i,
  input  nsip_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output nsip_pkg::res_t res_o
);
  localparam int unsigned IW = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;
  localparam int unsigned CW = $clog2(MaxSegments + 1);
  localparam int unsigned NST = 8;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StFin1 = 3'd2;
  localparam logic [2:0] StFin2 = 3'd3;
  localparam logic [2:0] StFin3 = 3'd4;
  localparam logic [2:0] StFin4 = 3'd5;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
  } seg_t;

  // Configuration registers.
  logic signed [31:0] cx_q, cy_q;
  logic [30:0]        rad_q;
  logic [8:0]         scnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      cy_q   <= '0;
      rad_q  <= 31'd65536;
      scnt_q <= 9'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nsip_pkg::RegCenterX: cx_q   <= cfg_data_i;
        nsip_pkg::RegCenterY: cy_q   <= cfg_data_i;
        nsip_pkg::RegRadius:  rad_q  <= cfg_data_i[30:0];
        nsip_pkg::RegSegCnt:  scnt_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Control state.
  logic [2:0]   state_q, state_d;
  logic [CW-1:0] addr_q, addr_d, n_q, n_d;
  logic [NST-1:0] v_q;
  logic [IW-1:0]  idx_q [NST];
  logic          issue, mem_we, pipe_busy;
  logic signed [31:0] px_q, py_q;

  assign pipe_busy = |v_q;
  assign issue     = (state_q == StScan) && (addr_q != n_q);
  assign mem_we    = (state_q == StIdle) && !cmd_empty_i &&
                     (cmd_i.action == nsip_pkg::ActLoad);
  assign cmd_pop_o = (state_q == StIdle) && !cmd_empty_i;
  assign res_push_o = (state_q == StFin4) && !res_full_i;

  // Effective search length: zero counts as one, large values clamp.
  always_comb begin
    if (scnt_q == 9'd0) begin
      n_d = CW'(1);
    end else if ({23'd0, scnt_q} > 32'(MaxSegments)) begin
      n_d = CW'(MaxSegments);
    end else begin
      n_d = CW'(scnt_q);
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    unique case (state_q)
      StIdle: begin
        if (!cmd_empty_i && cmd_i.action == nsip_pkg::ActQuery) begin
          state_d = StScan;
          addr_d  = '0;
        end
      end
      StScan: begin
        if (issue) begin
          addr_d = addr_q + CW'(1);
        end else if (!pipe_busy) begin
          state_d = StFin1;
        end
      end
      StFin1: state_d = StFin2;
      StFin2: state_d = StFin3;
      StFin3: state_d = StFin4;
      StFin4: begin
        if (!res_full_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      addr_q  <= '0;
      n_q     <= CW'(1);
      v_q     <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      if (state_q == StIdle) begin
        n_q <= n_d;
      end
      v_q <= {v_q[NST-2:0], issue};
    end
  end

  // Query point, held for the whole scan.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.action == nsip_pkg::ActQuery) begin
      px_q <= cmd_i.point_x;
      py_q <= cmd_i.point_y;
    end
  end

  // Segment table: one write port, one registered read port.
  seg_t mem_q [MaxSegments];
  seg_t rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[IW'(cmd_i.entry_index)] <= {cmd_i.point_x, cmd_i.point_y,
                                        cmd_i.dir_x, cmd_i.dir_y};
    end
    rd_q <= mem_q[addr_q[IW-1:0]];
  end

  // Segment index travels beside the data.
  always_ff @(posedge clk_i) begin
    idx_q[0] <= addr_q[IW-1:0];
    for (int k = 1; k < NST; k++) begin
      idx_q[k] <= idx_q[k-1];
    end
  end

  // Stage B: offset from start and the two dot-product terms.
  logic signed [32:0] rx, ry;
  logic signed [31:0] b_sx, b_sy;
  logic signed [15:0] b_dx, b_dy;
  logic signed [48:0] b_prx, b_pry;

  assign rx = 33'(px_q) - 33'(rd_q.sx);
  assign ry = 33'(py_q) - 33'(rd_q.sy);

  always_ff @(posedge clk_i) begin
    b_sx  <= rd_q.sx;
    b_sy  <= rd_q.sy;
    b_dx  <= rd_q.dx;
    b_dy  <= rd_q.dy;
    b_prx <= rd_q.dx * rx;
    b_pry <= rd_q.dy * ry;
  end

  // Stage C: rounded projection length t.
  logic signed [49:0] dot_r;
  logic signed [31:0] c_sx, c_sy;
  logic signed [15:0] c_dx, c_dy;
  logic signed [35:0] c_t;

  assign dot_r = 50'(b_prx) + 50'(b_pry) + 50'sd8192;

  always_ff @(posedge clk_i) begin
    c_sx <= b_sx;
    c_sy <= b_sy;
    c_dx <= b_dx;
    c_dy <= b_dy;
    c_t  <= dot_r[49:nsip_pkg::DirFrac];
  end

  // Stage D: direction times t.
  logic signed [31:0] d_sx, d_sy;
  logic signed [51:0] d_ox, d_oy;

  always_ff @(posedge clk_i) begin
    d_sx <= c_sx;
    d_sy <= c_sy;
    d_ox <= c_dx * c_t;
    d_oy <= c_dy * c_t;
  end

  // Stage E: projection point.
  logic signed [51:0] ox_r, oy_r;
  logic signed [37:0] offx, offy;
  logic signed [38:0] e_qx, e_qy;

  assign ox_r = d_ox + 52'sd8192;
  assign oy_r = d_oy + 52'sd8192;
  assign offx = ox_r[51:nsip_pkg::DirFrac];
  assign offy = oy_r[51:nsip_pkg::DirFrac];

  always_ff @(posedge clk_i) begin
    e_qx <= 39'(d_sx) + 39'(offx);
    e_qy <= 39'(d_sy) + 39'(offy);
  end

  // Stage F: distance magnitudes per axis.
  logic signed [39:0] ex, ey;
  logic signed [38:0] f_qx, f_qy;
  logic [39:0]        f_mx, f_my;

  assign ex = 40'(e_qx) - 40'(px_q);
  assign ey = 40'(e_qy) - 40'(py_q);

  always_ff @(posedge clk_i) begin
    f_qx <= e_qx;
    f_qy <= e_qy;
    f_mx <= ex[39] ? 40'(-ex) : 40'(ex);
    f_my <= ey[39] ? 40'(-ey) : 40'(ey);
  end

  // Stage G: squares as 20-bit partial products.
  logic signed [38:0] g_qx, g_qy;
  logic [39:0] g_xhh, g_xhl, g_xll, g_yhh, g_yhl, g_yll;

  always_ff @(posedge clk_i) begin
    g_qx  <= f_qx;
    g_qy  <= f_qy;
    g_xhh <= f_mx[39:20] * f_mx[39:20];
    g_xhl <= f_mx[39:20] * f_mx[19:0];
    g_xll <= f_mx[19:0] * f_mx[19:0];
    g_yhh <= f_my[39:20] * f_my[39:20];
    g_yhl <= f_my[39:20] * f_my[19:0];
    g_yll <= f_my[19:0] * f_my[19:0];
  end

  // Stage H: squared distance.
  logic signed [38:0] h_qx, h_qy;
  logic [80:0]        h_d;

  always_ff @(posedge clk_i) begin
    h_qx <= g_qx;
    h_qy <= g_qy;
    h_d  <= (81'(g_xhh) << 40) + (81'(g_xhl) << 21) + 81'(g_xll) +
            (81'(g_yhh) << 40) + (81'(g_yhl) << 21) + 81'(g_yll);
  end

  // Keep the strictly nearest; the first segment always loads.
  logic [80:0]        best_d_q;
  logic [IW-1:0]      best_idx_q;
  logic signed [38:0] bqx_q, bqy_q;
  logic               take;

  assign take = v_q[NST-1] && ((idx_q[NST-1] == '0) || (h_d < best_d_q));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_d_q   <= h_d;
      best_idx_q <= idx_q[NST-1];
      bqx_q      <= h_qx;
      bqy_q      <= h_qy;
    end
  end

  // Finish: saturated image point, circle distance, compare.
  logic signed [40:0] ix_w, iy_w;
  logic signed [31:0] ix_q, iy_q;
  logic signed [32:0] cdx, cdy;
  logic [32:0]        mcx_q, mcy_q;
  logic [65:0]        sqx_q, sqy_q;
  logic [61:0]        r2_q;
  logic [66:0]        circ_d;

  assign ix_w = (41'(bqx_q) <<< 1) - 41'(px_q);
  assign iy_w = (41'(bqy_q) <<< 1) - 41'(py_q);
  assign cdx  = 33'(ix_q) - 33'(cx_q);
  assign cdy  = 33'(iy_q) - 33'(cy_q);
  assign circ_d = 67'(sqx_q) + 67'(sqy_q);

  always_ff @(posedge clk_i) begin
    if (state_q == StFin1) begin
      if (ix_w > 41'sd2147483647) ix_q <= 32'sh7FFFFFFF;
      else if (ix_w < -41'sd2147483648) ix_q <= 32'sh80000000;
      else ix_q <= ix_w[31:0];
      if (iy_w > 41'sd2147483647) iy_q <= 32'sh7FFFFFFF;
      else if (iy_w < -41'sd2147483648) iy_q <= 32'sh80000000;
      else iy_q <= iy_w[31:0];
    end
    if (state_q == StFin2) begin
      mcx_q <= cdx[32] ? 33'(-cdx) : 33'(cdx);
      mcy_q <= cdy[32] ? 33'(-cdy) : 33'(cdy);
    end
    if (state_q == StFin3) begin
      sqx_q <= mcx_q * mcx_q;
      sqy_q <= mcy_q * mcy_q;
      r2_q  <= rad_q * rad_q;
    end
  end

  always_comb begin
    res_o.image_x       = ix_q;
    res_o.image_y       = iy_q;
    res_o.nearest_index = 8'(best_idx_q);
    res_o.inside_circle = !(67'(r2_q) < circ_d);
  end

  // Checks on the sequencer and the scan pipeline.
  a_we_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == StIdle && !pipe_busy)
    else $error("table written during a scan");
  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> addr_q < n_q)
    else $error("scan address beyond segment count");
  a_fin_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin1) |-> (v_q == '0) && addr_q == n_q)
    else $error("finish started with segments in flight");
  a_push_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |=> state_q == StIdle)
    else $error("result pushed without returning to idle");
endmodule

// ===== rtl/nearest_segment_image_point_top.sv =====
// Top level of the nearest segment image point block.
// Depends on nsip_pkg, nsip_front, nsip_fifo and nsip_engine.
//
// Usage: items enter through a queue-like port (push/full). A load item
// (action 0) writes one segment entry; a query item (action 1) searches
// segments 0 to segment_count-1 and yields one result item on the output
// queue port (empty/pop): the reflected image point, the nearest index and
// the inside-circle flag. Loads give no result.
// A load is written to the table from the idle state. A query issues one
// table read per cycle from the segment memory's read port; each read passes
// eight pipeline stages, then four finish steps follow, and queries are
// handled one at a time.
// A two-entry queue sits in front of the engine and another behind it, so
// items are taken while a result waits. When the receiver stalls, the
// engine holds its finished result until the output queue has room.
// Reset clears the queues and control and sets the registers to their
// defaults; segment entries hold nothing defined until loaded.
// Configuration is written with cfg_we_i while no item is in progress.
module nearest_segment_image_point_top #(
  parameter int unsigned MaxSegments = nsip_pkg::MaxSegmentsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic               action_i,
  input  logic [7:0]         entry_index_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] image_x_o,
  output logic signed [31:0] image_y_o,
  output logic [7:0]         nearest_index_o,
  output logic               inside_circle_o
);
  nsip_pkg::cmd_t cmd_in, cmd_out;
  nsip_pkg::res_t res_in, res_out;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty, res_push, res_full;

  // Front: accept and classify.
  nsip_front #(.MaxSegments(MaxSegments)) u_front (
    .push_i       (push),
    .full_o       (full),
    .action_i     (action_i),
    .entry_index_i(entry_index_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .dir_x_i      (dir_x_i),
    .dir_y_i      (dir_y_i),
    .cmd_full_i   (cmd_full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  // Item queue between front and engine.
  nsip_fifo #(.Width($bits(nsip_pkg::cmd_t)), .Depth(2)) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_out),
    .empty_o(cmd_empty)
  );

  // Engine: table, scan and finish.
  nsip_engine #(.MaxSegments(MaxSegments)) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  // Result queue toward the receiver.
  nsip_fifo #(.Width($bits(nsip_pkg::res_t)), .Depth(2)) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_out),
    .empty_o(empty)
  );

  assign image_x_o       = res_out.image_x;
  assign image_y_o       = res_out.image_y;
  assign nearest_index_o = res_out.nearest_index;
  assign inside_circle_o = res_out.inside_circle;
endmodule
